@@ hdl/vbpg_pkg.sv @@
// Package for the vector beam point generator: modes, opcodes, register indexes.
// No dependencies.
`default_nettype none
package vbpg_pkg;
  typedef enum logic [1:0] {
    OP_TICK = 2'd0, OP_MOVE = 2'd1, OP_LINE = 2'd2, OP_BAL = 2'd3
  } op_e;
  typedef enum logic [1:0] {
    MD_IDLE = 2'd0, MD_MOVE = 2'd1, MD_LINE = 2'd2, MD_BAL = 2'd3
  } mode_e;
  typedef enum logic [3:0] {
    ST_IDLE, ST_SQRT, ST_DIVN, ST_PT, ST_DIVX, ST_DIVY, ST_CLIP, ST_SUMX, ST_SUMY, ST_OUT
  } state_e;
  localparam logic [2:0] REG_XLO = 3'd0;
  localparam logic [2:0] REG_XHI = 3'd1;
  localparam logic [2:0] REG_YLO = 3'd2;
  localparam logic [2:0] REG_YHI = 3'd3;
  localparam logic [2:0] REG_OFX = 3'd4;
  localparam logic [2:0] REG_OFY = 3'd5;
  localparam logic [2:0] REG_SPC = 3'd6;
  localparam int ClampLim = 32767;
endpackage
`default_nettype wire

@@ hdl/vbpg_serdiv.sv @@
// Bit-serial restoring divider, one quotient bit per cycle (unsigned).
// Depends on nothing.
`default_nettype none
module vbpg_serdiv #(
  parameter int W = 34
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              done_o,
  output logic [W-1:0]      quo_o
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic run_q, run_d, done_q, done_d;
  logic [W:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    run_d = run_q; done_d = 1'b0;
    trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0; quo_d = num_i; den_d = den_i; cnt_d = CW'(W); run_d = 1'b1;
    end else if (run_q) begin
      // shift in one numerator bit, subtract if it fits
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end
  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

@@ hdl/vbpg_sersqrt.sv @@
// Digit-serial integer square root, one result bit (two radicand bits) per cycle.
// Depends on nothing.
`default_nettype none
module vbpg_sersqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [33:0] rad_i,
  output logic             done_o,
  output logic [16:0]      root_o
);
  logic [33:0] rad_q, rad_d;
  logic [18:0] rem_q, rem_d;
  logic [16:0] root_q, root_d;
  logic [4:0] cnt_q, cnt_d;
  logic run_q, run_d, done_q, done_d;
  logic [18:0] sh, tr;

  always_comb begin
    rad_d = rad_q; rem_d = rem_q; root_d = root_q; cnt_d = cnt_q;
    run_d = run_q; done_d = 1'b0;
    sh = {rem_q[16:0], rad_q[33:32]};
    tr = {root_q, 2'b01};
    if (start_i) begin
      rad_d = rad_i; rem_d = '0; root_d = '0; cnt_d = 5'd17; run_d = 1'b1;
    end else if (run_q) begin
      rad_d = {rad_q[31:0], 2'b00};
      if (sh >= tr) begin
        rem_d = sh - tr; root_d = {root_q[15:0], 1'b1};
      end else begin
        rem_d = sh; root_d = {root_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 5'd1) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rad_q <= rad_d; rem_q <= rem_d; root_q <= root_d;
  end
  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

@@ hdl/vector_beam_point_generator_unit.sv @@
// Top level of the vector beam point generator: command sequencer, clip and sums.
// Depends on vbpg_pkg, vbpg_sersqrt and vbpg_serdiv.
//
// Usage: items arrive on in_valid_i/in_ready_o (opcode_i, target_x_i, target_y_i),
// one result per item leaves on out_valid_o/out_ready_i. Configuration writes
// arrive on cfg_valid_i/cfg_ready_o (cfg_index_i, cfg_data_i); the user must
// write them only while idle, which the block does not enforce. Any command
// other than a line, and a tick while idle, goes straight to the result; a
// move tick goes through clip and sums (clip only when the point is clipped),
// a balance tick that forces a point through the sums and a check of the
// updated sums (straight to the result when the sums are already inside). A
// line command runs a 17-step serial square root and a 34-step serial divide.
// A line tick runs two 34-step serial divides for the interpolated x and y,
// then clip and sums, only clip when the point is clipped. The serial divider sets the rate.
// One item is in flight at a time; the next is taken the cycle after the
// result is transferred. A stalled receiver holds the result in the output
// register and the block waits with in_ready_o low.
// Reset: windows -16384..16383, offsets 0 and -2500, spacing 60, pen, sums
// and mode cleared; no clearing pass.
`default_nettype none
module vector_beam_point_generator_unit #(
  parameter int SUM_WIDTH    = 40,
  parameter int DWELL_POINTS = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vbpg_pkg::op_e      opcode_i,
  input  wire logic signed [15:0] target_x_i,
  input  wire logic signed [15:0] target_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    point_valid_o,
  output logic signed [15:0]      point_x_o,
  output logic signed [15:0]      point_y_o,
  output logic                    command_done_o,
  output logic                    rejected_o,
  output logic                    busy_res_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [16:0]        cfg_data_i
);
  import vbpg_pkg::*;

  localparam int SW = SUM_WIDTH;
  localparam int DW = $clog2(DWELL_POINTS + 1);
  localparam logic signed [SW-1:0] SumHi = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SumLo = {1'b1, {(SW-1){1'b0}}};

  // configuration registers
  logic signed [15:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic signed [16:0] ofx_q, ofy_q;
  logic [11:0] spc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xlo_q <= -16'sd16384; xhi_q <= 16'sd16383;
      ylo_q <= -16'sd16384; yhi_q <= 16'sd16383;
      ofx_q <= '0; ofy_q <= -17'sd2500; spc_q <= 12'd60;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_XLO: xlo_q <= cfg_data_i[15:0];
        REG_XHI: xhi_q <= cfg_data_i[15:0];
        REG_YLO: ylo_q <= cfg_data_i[15:0];
        REG_YHI: yhi_q <= cfg_data_i[15:0];
        REG_OFX: ofx_q <= cfg_data_i;
        REG_OFY: ofy_q <= cfg_data_i;
        REG_SPC: spc_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  // architectural state
  state_e st_q, st_d;
  mode_e md_q, md_d;
  logic signed [15:0] penx_q, penx_d, peny_q, peny_d, ssx_q, ssx_d, ssy_q, ssy_d;
  logic [16:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [DW-1:0] dw_q, dw_d;
  logic signed [SW-1:0] sx_q, sx_d, sy_q, sy_d;
  // working registers
  logic signed [17:0] px_q, px_d, py_q, py_d;
  logic neg_q, neg_d, emit_q, emit_d, force_q, force_d;
  logic ov_q, ov_d, dn_q, dn_d, rj_q, rj_d, bz_q, bz_d;
  logic [33:0] dnum_q, dnum_d;
  logic [33:0] dden;

  // serial units
  logic sq_start, sq_done, dv_start, dv_done;
  logic [33:0] sq_rad, dv_quo;
  logic [16:0] sq_root;
  logic signed [16:0] ddx, ddy;
  logic [16:0] adx, ady;

  assign ddx = 17'(target_x_i) - 17'(penx_q);
  assign ddy = 17'(target_y_i) - 17'(peny_q);
  assign adx = ddx[16] ? 17'(-ddx) : ddx;
  assign ady = ddy[16] ? 17'(-ddy) : ddy;
  assign sq_rad = 34'(adx * adx) + 34'(ady * ady);

  // the divider loads its numerator in the same cycle that start is raised
  vbpg_sersqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad),
                       .done_o(sq_done), .root_o(sq_root));
  vbpg_serdiv #(.W(34)) u_div (.clk_i, .rst_ni, .start_i(dv_start), .num_i(dnum_d),
                               .den_i(dden), .done_o(dv_done), .quo_o(dv_quo));

  // signed products for interpolation: x in ST_PT, y once the x divide is done
  logic signed [16:0] dlt;
  logic signed [34:0] prod;
  logic [33:0] aprod;
  logic signed [17:0] qs;
  logic signed [SW-1:0] addend, sacc, ssum;
  logic signed [SW:0] wsum;
  logic signed [17:0] cx, cy;
  logic [SW-1:0] csrc;
  logic signed [15:0] clampv;
  logic outside;

  assign qs = neg_q ? -$signed({1'b0, dv_quo[16:0]}) : $signed({1'b0, dv_quo[16:0]});
  assign outside = (sx_q <= SW'(xlo_q)) || (sx_q >= SW'(xhi_q)) ||
                   (sy_q <= SW'(ylo_q)) || (sy_q >= SW'(yhi_q));

  always_comb begin
    st_d = st_q; md_d = md_q;
    penx_d = penx_q; peny_d = peny_q; ssx_d = ssx_q; ssy_d = ssy_q;
    cnt_d = cnt_q; idx_d = idx_q; dw_d = dw_q; sx_d = sx_q; sy_d = sy_q;
    px_d = px_q; py_d = py_q; neg_d = neg_q; emit_d = emit_q; force_d = force_q;
    ov_d = ov_q; dn_d = dn_q; rj_d = rj_q; bz_d = bz_q;
    dnum_d = dnum_q;
    sq_start = 1'b0; dv_start = 1'b0;
    dden = {17'd0, cnt_q};
    dlt = '0; prod = '0; aprod = '0;
    addend = '0; sacc = '0; wsum = '0; ssum = '0;
    cx = '0; cy = '0; csrc = '0; clampv = '0;
    in_ready_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dn_d = 1'b0; rj_d = 1'b0; bz_d = 1'b1;
          emit_d = 1'b0; force_d = 1'b0; st_d = ST_OUT;
          if (opcode_i != OP_TICK) begin
            if (md_q != MD_IDLE) rj_d = 1'b1;
            else if (opcode_i == OP_MOVE) begin
              ssx_d = penx_q; ssy_d = peny_q; penx_d = target_x_i; peny_d = target_y_i;
              dw_d = '0; idx_d = '0; md_d = MD_MOVE;
            end else if (opcode_i == OP_LINE) begin
              // hold targets in the point regs until the length is known
              px_d = 18'(target_x_i); py_d = 18'(target_y_i);
              sq_start = 1'b1; st_d = ST_SQRT;
            end else md_d = MD_BAL;
          end else begin
            unique case (md_q)
              MD_IDLE: bz_d = 1'b0;
              MD_MOVE: begin
                px_d = (idx_q == '0) ? 18'(ssx_q) : 18'(penx_q);
                py_d = (idx_q == '0) ? 18'(ssy_q) : 18'(peny_q);
                emit_d = 1'b1; st_d = ST_CLIP;
                if (dw_q == DW'(DWELL_POINTS - 1)) begin
                  dw_d = '0;
                  if (idx_q == '0) idx_d = 17'd1;
                  else dn_d = 1'b1;
                end else dw_d = dw_q + 1'b1;
              end
              MD_LINE: begin
                emit_d = 1'b1; st_d = ST_PT;
              end
              MD_BAL: begin
                if (outside) begin
                  emit_d = 1'b1; force_d = 1'b1; st_d = ST_SUMX;
                  csrc = sx_q;
                end else begin
                  dn_d = 1'b1; st_d = ST_OUT;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_SQRT: if (sq_done) begin
        dnum_d = {17'd0, sq_root};
        dv_start = 1'b1; st_d = ST_DIVN;
        dden = {22'd0, (spc_q == '0) ? 12'd1 : spc_q};
      end
      ST_DIVN: begin
        dden = {22'd0, (spc_q == '0) ? 12'd1 : spc_q};
        if (dv_done) begin
          cnt_d = (dv_quo[16:0] == '0) ? 17'd1 : dv_quo[16:0];
          idx_d = '0; ssx_d = penx_q; ssy_d = peny_q;
          penx_d = px_q[15:0]; peny_d = py_q[15:0]; md_d = MD_LINE; st_d = ST_OUT;
        end
      end
      ST_PT: begin
        // x product magnitude, divide by count
        dlt = 17'(penx_q) - 17'(ssx_q);
        prod = dlt * $signed({1'b0, idx_q});
        neg_d = prod[34];
        aprod = prod[34] ? 34'(-prod) : prod[33:0];
        dnum_d = aprod; dv_start = 1'b1; st_d = ST_DIVX;
      end
      ST_DIVX: if (dv_done) begin
        px_d = 18'(ssx_q) + qs;
        dlt = 17'(peny_q) - 17'(ssy_q);
        prod = dlt * $signed({1'b0, idx_q});
        neg_d = prod[34];
        aprod = prod[34] ? 34'(-prod) : prod[33:0];
        dnum_d = aprod; dv_start = 1'b1; st_d = ST_DIVY;
      end
      ST_DIVY: if (dv_done) begin
        py_d = 18'(ssy_q) + qs;
        if (idx_q >= cnt_q) dn_d = 1'b1;
        else idx_d = idx_q + 1'b1;
        st_d = ST_CLIP;
      end
      ST_CLIP: begin
        cx = px_q + 18'(ofx_q); cy = py_q + 18'(ofy_q);
        px_d = cx; py_d = cy;
        if (cx < 18'(xlo_q) || cx > 18'(xhi_q) || cy < 18'(ylo_q) || cy > 18'(yhi_q)) begin
          emit_d = 1'b0; st_d = ST_OUT;
        end else st_d = ST_SUMX;
      end
      ST_SUMX: begin
        if (force_q) begin
          csrc = sx_q;
          clampv = ($signed(csrc) > SW'(ClampLim)) ? -16'sd32767 :
                   ($signed(csrc) < -SW'(ClampLim)) ? 16'sd32767 : 16'(-$signed(csrc));
          px_d = 18'(clampv);
          csrc = sy_q;
          clampv = ($signed(csrc) > SW'(ClampLim)) ? -16'sd32767 :
                   ($signed(csrc) < -SW'(ClampLim)) ? 16'sd32767 : 16'(-$signed(csrc));
          py_d = 18'(clampv);
          addend = SW'(px_d);
        end else addend = SW'(px_q);
        sacc = sx_q;
        wsum = (SW+1)'(sacc) + (SW+1)'(addend);
        ssum = (wsum[SW] != wsum[SW-1]) ? (wsum[SW] ? SumLo : SumHi) : wsum[SW-1:0];
        sx_d = ssum; st_d = ST_SUMY;
      end
      ST_SUMY: begin
        addend = SW'(py_q); sacc = sy_q;
        wsum = (SW+1)'(sacc) + (SW+1)'(addend);
        ssum = (wsum[SW] != wsum[SW-1]) ? (wsum[SW] ? SumLo : SumHi) : wsum[SW-1:0];
        sy_d = ssum; st_d = ST_OUT; ov_d = force_q;
      end
      ST_OUT: begin
        // balance finishes once the updated sums are inside
        if (ov_q) begin
          ov_d = 1'b0;
          if (!outside) dn_d = 1'b1;
        end else if (out_ready_i) begin
          if (dn_q) begin md_d = MD_IDLE; idx_d = '0; end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; md_q <= MD_IDLE;
      penx_q <= '0; peny_q <= '0; ssx_q <= '0; ssy_q <= '0;
      cnt_q <= '0; idx_q <= '0; dw_q <= '0; sx_q <= '0; sy_q <= '0;
      ov_q <= 1'b0; emit_q <= 1'b0; force_q <= 1'b0;
      dn_q <= 1'b0; rj_q <= 1'b0; bz_q <= 1'b0;
    end else begin
      st_q <= st_d; md_q <= md_d;
      penx_q <= penx_d; peny_q <= peny_d; ssx_q <= ssx_d; ssy_q <= ssy_d;
      cnt_q <= cnt_d; idx_q <= idx_d; dw_q <= dw_d; sx_q <= sx_d; sy_q <= sy_d;
      ov_q <= ov_d; emit_q <= emit_d; force_q <= force_d;
      dn_q <= dn_d; rj_q <= rj_d; bz_q <= bz_d;
    end
  end
  always_ff @(posedge clk_i) begin
    px_q <= px_d; py_q <= py_d; neg_q <= neg_d; dnum_q <= dnum_d;
  end

  assign out_valid_o    = (st_q == ST_OUT) && !ov_q;
  assign point_valid_o  = emit_q;
  assign point_x_o      = emit_q ? px_q[15:0] : 16'sd0;
  assign point_y_o      = emit_q ? py_q[15:0] : 16'sd0;
  assign command_done_o = dn_q;
  assign rejected_o     = rj_q;
  assign busy_res_o     = bz_q && !dn_q;

  // assertions
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input taken while result pending");
  a_rej_nopt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> !point_valid_o && !command_done_o)
    else $error("rejected result carries a point");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && command_done_o |=> md_q == MD_IDLE)
    else $error("mode not idle after done");
endmodule
`default_nettype wire
